// ----- rtl/tpbf_pkg.sv -----
package tpbf_pkg;

    // protocol and length limits of the filter
    localparam logic [7:0]  TCP_PROTO         = 8'd6;
    localparam logic [15:0] MIN_FRAME_BYTES   = 16'd54;

    // sizing defaults
    localparam int          DEF_TABLE_ENTRIES = 16;
    localparam int          QUEUE_DEPTH       = 4;

    // one header summary as it arrives
    typedef struct packed {
        logic [15:0] frame_length;
        logic [7:0]  ip_protocol;
        logic [15:0] tcp_dest_port;
        logic [31:0] source_address;
    } t_in_word;

    // one verdict as it leaves
    typedef struct packed {
        logic        verdict;
        logic [31:0] source_count;
        logic        new_entry;
        logic        evicted;
    } t_out_word;

    // classified word carried from front to back
    typedef struct packed {
        logic        drop;
        logic [31:0] source_address;
    } t_job;

    // queue status seen by the back end and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- rtl/tpbf_front.sv -----
module tpbf_front
    import tpbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  t_in_word    i_header,
    output t_job        o_job
);

    logic [15:0] r_port;

    // blocked port register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port <= 16'd0;
        end else if (i_cfg_valid) begin
            r_port <= i_cfg_data;
        end
    end

    // classify: long enough, tcp, blocked port
    always_comb begin
        o_job.source_address = i_header.source_address;
        o_job.drop = (i_header.frame_length >= MIN_FRAME_BYTES)
                  && (i_header.ip_protocol == TCP_PROTO)
                  && (i_header.tcp_dest_port == r_port);
    end

endmodule

// ----- rtl/tpbf_fifo.sv -----
module tpbf_fifo
    import tpbf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_job   i_wdata,
    input  logic   i_rd,
    output t_job   o_rdata,
    output t_qstat o_stat
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W:0]   r_wr_ptr;
    logic [QA_W:0]   r_rd_ptr;
    logic            wr_ok;
    logic            rd_ok;

    // pointer compare with wrap bit
    assign o_stat.empty = (r_wr_ptr == r_rd_ptr);
    assign o_stat.full  = (r_wr_ptr[QA_W] != r_rd_ptr[QA_W])
                       && (r_wr_ptr[QA_W-1:0] == r_rd_ptr[QA_W-1:0]);
    assign wr_ok   = i_wr && !o_stat.full;
    assign rd_ok   = i_rd && !o_stat.empty;
    assign o_rdata = r_mem[r_rd_ptr[QA_W-1:0]];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr[QA_W-1:0]] <= i_wdata;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tpbf_back.sv -----
module tpbf_back
    import tpbf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qstat    i_qstat,
    input  t_job      i_job,
    output logic      o_qpop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] OLDEST = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    localparam logic [1:0] K_PASS  = 2'd0;
    localparam logic [1:0] K_HIT   = 2'd1;
    localparam logic [1:0] K_NEW   = 2'd2;
    localparam logic [1:0] K_EVICT = 2'd3;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    t_job                     r_job;
    logic [1:0]               r_kind;
    logic [1:0]               n_kind;
    logic [IDX_W-1:0]         r_tgt;
    logic [IDX_W-1:0]         n_tgt;
    logic [IDX_W-1:0]         r_thr;
    logic [IDX_W-1:0]         n_thr;
    logic [31:0]              r_old_cnt;
    logic                     r_out_valid;
    t_out_word                r_out;
    t_out_word                n_out;

    logic [31:0]              r_key   [TABLE_ENTRIES];
    logic [31:0]              r_count [TABLE_ENTRIES];
    logic [IDX_W-1:0]         r_rank  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                     hit_found;
    logic [IDX_W-1:0]         hit_idx;
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         vict_idx;
    logic                     out_free;
    logic                     fire;
    logic [31:0]              upd_cnt;

    assign out_free = !r_out_valid || i_pop;
    assign fire     = (r_state == S_UPD) && out_free;
    assign o_qpop   = !i_qstat.empty && ((r_state == S_IDLE) || fire);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign upd_cnt  = (r_kind == K_HIT) ? (r_old_cnt + 32'd1) : 32'd1;

    // associative match, lowest free slot, oldest entry
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        vict_idx   = '0;
        for (int j = TABLE_ENTRIES - 1; j >= 0; j--) begin
            if (r_valid[j] && (r_key[j] == r_job.source_address)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(j);
            end
            if (!r_valid[j]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(j);
            end
            if (r_rank[j] == OLDEST) begin
                vict_idx = IDX_W'(j);
            end
        end
    end

    // decide what the update does
    always_comb begin
        n_kind = K_PASS;
        n_tgt  = '0;
        n_thr  = '0;
        if (r_job.drop) begin
            if (hit_found) begin
                n_kind = K_HIT;
                n_tgt  = hit_idx;
                n_thr  = r_rank[hit_idx];
            end else if (free_found) begin
                n_kind = K_NEW;
                n_tgt  = free_idx;
            end else begin
                n_kind = K_EVICT;
                n_tgt  = vict_idx;
                n_thr  = OLDEST;
            end
        end
    end

    // sequencer: fetch, look up, update
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = i_qstat.empty ? S_IDLE : S_LOOK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result word
    always_comb begin
        n_out.verdict      = (r_kind != K_PASS);
        n_out.source_count = (r_kind == K_PASS) ? 32'd0 : upd_cnt;
        n_out.new_entry    = r_kind inside {K_NEW, K_EVICT};
        n_out.evicted      = (r_kind == K_EVICT);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            r_job <= i_job;
        end
        if (r_state == S_LOOK) begin
            r_kind    <= n_kind;
            r_tgt     <= n_tgt;
            r_thr     <= n_thr;
            r_old_cnt <= r_count[hit_idx];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // keys and counts
    always_ff @(posedge i_clk) begin
        if (fire && (r_kind != K_PASS)) begin
            r_count[r_tgt] <= upd_cnt;
            if (r_kind inside {K_NEW, K_EVICT}) begin
                r_key[r_tgt] <= r_job.source_address;
            end
        end
    end

    // valid bits and recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (fire && (r_kind != K_PASS)) begin
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                if (IDX_W'(j) == r_tgt) begin
                    r_rank[j] <= '0;
                end else if (r_valid[j] && ((r_kind == K_NEW) || (r_rank[j] < r_thr))) begin
                    r_rank[j] <= r_rank[j] + 1'b1;
                end
            end
            r_valid[r_tgt] <= 1'b1;
        end
    end

    // checks
    a_evict_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && (r_kind == K_EVICT) |-> (&r_valid))
        else $error("eviction with a free slot");

    a_evict_new : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.evicted |-> r_out.new_entry && r_out.verdict)
        else $error("eviction without insertion");

    a_pass_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.verdict |-> (r_out.source_count == 32'd0) && !r_out.new_entry)
        else $error("passed word carries a count");

    a_new_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.new_entry |-> (r_out.source_count == 32'd1))
        else $error("new entry count not one");

    a_pop_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qpop |=> (r_state == S_LOOK))
        else $error("fetched word not looked up");

endmodule

// ----- rtl/tcp_port_block_filter_with_lru_counts.sv -----
// tcp destination port filter with per-source drop counts
//
// input channel: header summary on i_header, written with push while full
// is low. result channel: verdict word on o_result while empty is low,
// taken with pop. blocked port is written on i_cfg_data with i_cfg_valid;
// o_cfg_ready is always high, write only while the block is idle.
//
// a short queue parts classification from the table. the back end handles
// one word at a time in two states: a look-up state for the associative
// match over all entries and an update state for the count and recency
// update, and it fetches its next word as the update completes. a word
// accepted into an empty block passes through the queue, the idle fetch,
// the look-up and update states before it shows on the result ports.
// reset clears the blocked port to zero, empties the queue and clears all
// table valid bits and ranks at once. while pop is held low the finished
// result waits in the output register, the back end holds its next word,
// and the queue keeps accepting until full rises.
module tcp_port_block_filter_with_lru_counts
    import tpbf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_word    i_header,
    output logic        empty,
    input  logic        pop,
    output t_out_word   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_job   front_job;
    t_job   queue_job;
    t_qstat queue_stat;
    logic   queue_pop;

    assign full = queue_stat.full;

    // classification and port register
    tpbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_header    (i_header),
        .o_job       (front_job)
    );

    // decoupling queue
    tpbf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_job),
        .i_rd    (queue_pop),
        .o_rdata (queue_job),
        .o_stat  (queue_stat)
    );

    // source table and result register
    tpbf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (queue_stat),
        .i_job    (queue_job),
        .o_qpop   (queue_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

// ----- bench/tb_tcp_port_block_filter_with_lru_counts.sv -----
`timescale 1ns / 100ps

module tb_tcp_port_block_filter_with_lru_counts;
    import tpbf_pkg::*;

    localparam int         ENTRIES          = DEF_TABLE_ENTRIES;
    localparam int         POOL_SIZE        = 24;
    localparam int         PHASES           = 8;
    localparam int         PHASE_WORDS      = 150;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam logic [7:0] UDP_PROTO        = 8'd17;
    localparam t_out_word  PASSED           = '0;

    typedef struct {
        t_in_word  hdr;
        bit        pinned;
        t_out_word want;
    } t_drill_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_word    i_header;
    logic        empty;
    logic        pop;
    t_out_word   o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    // shadow of the filter: blocked port and the per-source table
    logic [15:0] port_shadow;
    logic [31:0] src_key   [ENTRIES];
    logic [31:0] src_count [ENTRIES];
    bit          src_valid [ENTRIES];
    logic [3:0]  src_rank  [ENTRIES];

    t_out_word   pending_verdicts[$];
    t_drill_row  drill_rows[$];
    logic [31:0] addr_pool[POOL_SIZE];
    int          error_count;
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_results;
    bit          hold_served;

    tcp_port_block_filter_with_lru_counts i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_header    (i_header),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("timeout with %0d words outstanding", pending_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // mostly back to back, some short gaps and the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // entry idx becomes most recent, younger valid entries age by one
    function automatic void promote_entry(int idx);
        for (int j = 0; j < ENTRIES; j++) begin
            if (j != idx && src_valid[j] && src_rank[j] < src_rank[idx])
                src_rank[j] = src_rank[j] + 4'd1;
        end
        src_rank[idx] = '0;
    endfunction

    // verdict for one header, updating the shadow table on a drop
    function automatic t_out_word predict_verdict(t_in_word w);
        t_out_word res;
        int        hit;
        int        free_slot;
        int        victim;
        res       = PASSED;
        hit       = -1;
        free_slot = -1;
        victim    = 0;
        if (w.frame_length < MIN_FRAME_BYTES || w.ip_protocol != TCP_PROTO ||
                w.tcp_dest_port != port_shadow)
            return res;
        for (int j = 0; j < ENTRIES; j++) begin
            if (src_valid[j]) begin
                if (hit < 0 && src_key[j] == w.source_address)
                    hit = j;
                if (!src_valid[victim] || src_rank[j] > src_rank[victim])
                    victim = j;
            end else if (free_slot < 0) begin
                free_slot = j;
            end
        end
        res.verdict = 1'b1;
        if (hit >= 0) begin
            src_count[hit]   = src_count[hit] + 32'd1;
            res.source_count = src_count[hit];
            promote_entry(hit);
        end else if (free_slot >= 0) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (src_valid[j])
                    src_rank[j] = src_rank[j] + 4'd1;
            end
            src_valid[free_slot] = 1'b1;
            src_key[free_slot]   = w.source_address;
            src_count[free_slot] = 32'd1;
            src_rank[free_slot]  = '0;
            res.source_count     = 32'd1;
            res.new_entry        = 1'b1;
        end else begin
            src_key[victim]   = w.source_address;
            src_count[victim] = 32'd1;
            promote_entry(victim);
            res.source_count  = 32'd1;
            res.new_entry     = 1'b1;
            res.evicted       = 1'b1;
        end
        return res;
    endfunction

    // offer one header word and record its verdict once taken
    task automatic send_word(input t_in_word w, input bit pinned, input t_out_word want);
        t_out_word predicted;
        int        gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push     = 1'b1;
        i_header = w;
        do
            @(posedge i_clk);
        while (full);
        predicted = predict_verdict(w);
        pending_verdicts.push_back(pinned ? want : predicted);
    endtask

    // stop offering and wait until every verdict is back
    task automatic drain_verdicts();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // port register write, only with the block idle
    task automatic write_blocked_port(input logic [15:0] value);
        drain_verdicts();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        port_shadow = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(input logic [15:0] flen, input logic [7:0] proto,
                           input logic [15:0] dport, input logic [31:0] src,
                           input bit pinned, input t_out_word want);
        t_drill_row row;
        row.hdr  = {flen, proto, dport, src};
        row.pinned = pinned;
        row.want = want;
        drill_rows.push_back(row);
    endtask

    // mostly drops from a source pool of the given span, the rest noise
    function automatic t_in_word random_word(int span);
        t_in_word w;
        int       r;
        r = $urandom_range(0, 99);
        w.frame_length   = (r < 5) ? MIN_FRAME_BYTES
                                   : 16'($urandom_range(MIN_FRAME_BYTES, 16'hFFFF));
        w.ip_protocol    = TCP_PROTO;
        w.tcp_dest_port  = port_shadow;
        w.source_address = ($urandom_range(0, 9) == 0) ? $urandom()
                                                        : addr_pool[$urandom_range(0, span - 1)];
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 3))
                0: w.frame_length = 16'($urandom_range(0, MIN_FRAME_BYTES - 1));
                1: w.ip_protocol = 8'($urandom());
                2: w.tcp_dest_port = 16'($urandom());
                default: begin
                    w.frame_length   = 16'($urandom());
                    w.ip_protocol    = 8'($urandom());
                    w.tcp_dest_port  = 16'($urandom());
                    w.source_address = $urandom();
                end
            endcase
        end
        return w;
    endfunction

    // receiver: random pop gaps, plus one long hold on request
    initial begin
        int rx_wait;
        pop         = 1'b0;
        rx_wait     = 0;
        hold_served = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results && !hold_served) begin
                pop = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                hold_served = 1'b1;
            end
            if (rx_wait > 0) begin
                pop = 1'b0;
                rx_wait--;
            end else begin
                pop = 1'b1;
                if (!rx_steady)
                    rx_wait = pick_gap();
            end
        end
    end

    // result check against the oldest waiting verdict
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected word, source_count", o_result.source_count, '0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_result.verdict !== want.verdict)
                    report_mismatch("verdict", 32'(o_result.verdict), 32'(want.verdict));
                if (o_result.source_count !== want.source_count)
                    report_mismatch("source_count", o_result.source_count, want.source_count);
                if (o_result.new_entry !== want.new_entry)
                    report_mismatch("new_entry", 32'(o_result.new_entry), 32'(want.new_entry));
                if (o_result.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(o_result.evicted), 32'(want.evicted));
            end
        end
    end

    // stimulus
    initial begin
        logic [15:0] port_value;
        int          span;
        push         = 1'b0;
        i_header     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_results = 1'b0;
        error_count  = 0;
        port_shadow  = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            src_valid[j] = 1'b0;
            src_rank[j]  = '0;
            src_key[j]   = '0;
            src_count[j] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int j = 2; j < POOL_SIZE; j++)
            addr_pool[j] = $urandom();

        // directed words, blocked port still at its reset value of zero
        add_row(16'd0, TCP_PROTO, 16'd0, 32'h0, 1'b1, PASSED);
        add_row(MIN_FRAME_BYTES - 16'd1, TCP_PROTO, 16'd0, 32'h0, 1'b1, PASSED);
        add_row(MIN_FRAME_BYTES, TCP_PROTO, 16'd0, 32'hC0A8_0001, 1'b1,
                {1'b1, 32'd1, 1'b1, 1'b0});
        add_row(16'd1500, TCP_PROTO, 16'd0, 32'hC0A8_0001, 1'b1,
                {1'b1, 32'd2, 1'b0, 1'b0});
        add_row(16'hFFFF, TCP_PROTO, 16'd0, 32'hFFFF_FFFF, 1'b1,
                {1'b1, 32'd1, 1'b1, 1'b0});
        add_row(16'hFFFF, UDP_PROTO, 16'd0, 32'h0, 1'b1, PASSED);
        add_row(16'hFFFF, 8'hFF, 16'd0, 32'hFFFF_FFFF, 1'b1, PASSED);
        add_row(16'd60, 8'h00, 16'd0, 32'h0, 1'b1, PASSED);
        add_row(16'd60, TCP_PROTO, 16'd1, 32'h0, 1'b1, PASSED);
        add_row(16'd60, TCP_PROTO, 16'hFFFF, 32'h0, 1'b1, PASSED);
        // fill the table with new sources
        for (int j = 1; j <= ENTRIES - 2; j++)
            add_row(16'd64, TCP_PROTO, 16'd0, 32'h0A00_0000 + 32'(j), 1'b0, PASSED);
        // table full: the least recent source is pushed out
        add_row(16'd64, TCP_PROTO, 16'd0, 32'h0B00_0000, 1'b1,
                {1'b1, 32'd1, 1'b1, 1'b1});
        // known source in the middle of the order
        add_row(16'd64, TCP_PROTO, 16'd0, 32'h0A00_0007, 1'b0, PASSED);

        foreach (drill_rows[k])
            send_word(drill_rows[k].hdr, drill_rows[k].pinned, drill_rows[k].want);

        // random phases, each starting with a write of its blocked port
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 6:    port_value = 16'hFFFF;
                2:       port_value = 16'h0000;
                4:       port_value = 16'd80;
                default: port_value = 16'($urandom());
            endcase
            case (p % 4)
                0:       span = 4;
                1:       span = ENTRIES;
                2:       span = ENTRIES + 1;
                default: span = POOL_SIZE;
            endcase
            write_blocked_port(port_value);
            tx_steady = (p == 1 || p == 3);
            rx_steady = (p == 1);
            // long receiver hold while the sender keeps offering
            if (p == 3)
                hold_results = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(span), 1'b0, PASSED);
        end

        drain_verdicts();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tpbf_pkg.sv
rtl/tpbf_front.sv
rtl/tpbf_fifo.sv
rtl/tpbf_back.sv
rtl/tcp_port_block_filter_with_lru_counts.sv
bench/tb_tcp_port_block_filter_with_lru_counts.sv
